[rtl/core/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha_pkg
// Constants and round functions shared by the stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned CountBits  = 61;

  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [31:0] word_t;

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    word_t      digest_word;
    logic [2:0] word_index;
    logic       last_word;
  } out_beat_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

[rtl/core/sha_stream_if.sv]
// ----------------------------------------------------------------------------
// sha_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface sha_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/sha256_stream_hasher_top.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// SHA-256 over a byte stream: bytes packed into a word memory, one round per
// cycle compression, digest streamed as eight words.
//
//  channel | dir | payload
//  in_ch   | in  | data_byte[7:0], has_byte, end_of_message
//  out_ch  | out | digest_word[31:0], word_index[2:0], last_word
//
// in_ch accepts bytes back to back until a block fills. The 64th byte closes
// in_ch while the block is hashed: start, 16-word load, 64 rounds, chaining add.
// End of message: pad bytes are written one at a time up to byte 55, then the
// two length words, and each padded block is hashed (a second block when the
// pad overflows); then each digest word is read and held until out_ch.ready.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top
  import sha_pkg::*;
(
  input logic clk,
  input logic rst,
  sha_stream_if.sink   in_ch,
  sha_stream_if.source out_ch
);

  typedef enum logic [5:0] {
    S_IN    = 6'b000001,
    S_HASH  = 6'b000010,
    S_PAD   = 6'b000100,
    S_LEN   = 6'b001000,
    S_READ  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;

  logic [CountBits-1:0] count;
  logic [23:0] acc;             // bytes of current word before the last
  logic        fin;             // padding pending after current compress
  logic        pad_mark;        // 0x80 byte still owed
  logic        len_blk;         // current compress is the last one
  logic [5:0]  pos;
  logic [2:0]  oidx;
  logic        ovalid;
  word_t       oword;
  logic [2:0]  oidx_q;

  logic       start, busy, done;
  logic       wr_en;
  logic [3:0] wr_addr;
  word_t      wr_data;
  logic       h_init;
  word_t      h_rd_data;
  logic [63:0] bits;

  in_beat_t ib;
  assign ib = in_ch.payload;
  assign bits = {count, 3'b000};

  sha_core u_core (
    .clk, .rst, .start, .busy, .done, .wr_en, .wr_addr, .wr_data, .h_init,
    .h_rd_addr(oidx), .h_rd_data
  );

  assign in_ch.ready = (state == S_IN);
  logic take;
  assign take = in_ch.valid && in_ch.ready;

  // byte to write into the current word position
  logic [7:0] byte_in;
  logic       byte_we;
  always_comb begin
    byte_we = 1'b0;
    byte_in = ib.data_byte;
    if (state == S_IN && take && ib.has_byte) begin
      byte_we = 1'b1;
    end
    if (state == S_PAD) begin
      byte_we = 1'b1;
      byte_in = pad_mark ? PadByte : 8'h00;
    end
    wr_en   = byte_we;
    wr_addr = pos[5:2];
    // partial words go in left-aligned and are rewritten as they fill;
    // shift is (3 - pos[1:0]) bytes
    wr_data = {acc, byte_in} << {~pos[1:0], 3'b000};
    if (state == S_LEN) begin
      wr_data = (pos[5:2] == 4'd14) ? bits[63:32] : bits[31:0];
      wr_en   = 1'b1;
    end
    start  = (state == S_HASH) && !busy;
    h_init = (state == S_OUT) && ovalid && out_ch.ready && oidx_q == 3'd7;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IN;
      count    <= '0;
      pos      <= '0;
      fin      <= 1'b0;
      pad_mark <= 1'b0;
      len_blk  <= 1'b0;
      ovalid   <= 1'b0;
      oidx     <= '0;
    end else begin
      unique case (state)
        S_IN: if (take) begin
          if (ib.has_byte) begin
            acc   <= (pos[1:0] == 2'd3) ? 24'h0 : {acc[15:0], ib.data_byte};
            pos   <= pos + 6'd1;
            count <= count + CountBits'(1);
          end
          if (ib.has_byte && pos == 6'd63) begin
            fin      <= ib.end_of_message;
            pad_mark <= ib.end_of_message;
            len_blk  <= 1'b0;
            state    <= S_HASH;
          end else if (ib.end_of_message) begin
            fin      <= 1'b1;
            pad_mark <= 1'b1;
            state    <= S_PAD;
          end
        end
        S_HASH: begin
          // wait for core start then completion
          if (done) begin
            if (len_blk) begin
              oidx  <= '0;
              state <= S_READ;
            end else if (fin) begin
              pos   <= '0;
              state <= S_PAD;
            end else begin
              pos   <= '0;
              state <= S_IN;
            end
          end
        end
        S_PAD: begin
          pad_mark <= 1'b0;
          acc <= (pos[1:0] == 2'd3) ? 24'h0 : {acc[15:0], byte_in};
          pos <= pos + 6'd1;
          if (pos[1:0] == 2'd3 && pos[5:2] == 4'd13) begin
            state <= S_LEN;
          end else if (pos == 6'd63) begin
            len_blk <= 1'b0;
            state   <= S_HASH;
          end
        end
        S_LEN: begin
          pos <= pos + 6'd4;
          if (pos[5:2] == 4'd15) begin
            len_blk <= 1'b1;
            fin     <= 1'b0;
            state   <= S_HASH;
          end
        end
        S_READ: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!ovalid) begin
            ovalid <= 1'b1;
            oword  <= h_rd_data;
            oidx_q <= oidx;
          end else if (out_ch.ready) begin
            ovalid <= 1'b0;
            if (oidx_q == 3'd7) begin
              count   <= '0;
              pos     <= '0;
              acc     <= '0;
              len_blk <= 1'b0;
              state   <= S_IN;
            end else begin
              oidx  <= oidx + 3'd1;
              state <= S_READ;
            end
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

  // fin keeps the padding going across an overflow block; pad_mark covers
  // the single 0x80 byte, which may land at the start of that block

  out_beat_t ob;
  assign ob.digest_word = oword;
  assign ob.word_index  = oidx_q;
  assign ob.last_word   = (oidx_q == 3'd7);
  assign out_ch.valid   = ovalid;
  assign out_ch.payload = ob;

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ch.ready) else $error("input open while hashing");
  a_out_in_state: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> state == S_OUT) else $error("output beat outside drain");
  a_reset_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && ob.last_word) |=> count == '0)
    else $error("count not cleared after digest");
`endif

endmodule

[rtl/core/sha_core.sv]
// ----------------------------------------------------------------------------
// sha_core
// One round per cycle SHA-256 compression. Message words sit in a 16-entry
// memory copied into a sliding window for the schedule; chaining words live in an 8-entry
// memory updated at the end of each block.
// ----------------------------------------------------------------------------
module sha_core
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output logic       done,
  input  logic       wr_en,       // block word write from the byte packer
  input  logic [3:0] wr_addr,
  input  word_t      wr_data,
  input  logic       h_init,      // restore initial chaining values
  input  logic [2:0] h_rd_addr,
  output word_t      h_rd_data
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOAD  = 4'b0010,
    ST_ROUND = 4'b0100,
    ST_ADD   = 4'b1000
  } state_t;

  state_t state, state_next;

  // schedule memory: four reads a round are done from a small register file
  // shadow since the memory only offers one port; the window is held locally
  word_t w_mem [BlockWords];
  word_t win [BlockWords];     // sliding window, win[0] = oldest
  word_t h_mem [8];
  logic  h_valid_n;            // high after init: reads return InitH
  word_t v [8];
  logic [5:0] rnd;
  logic [3:0] cnt;
  logic [2:0] h_wa;            // entry read in the previous cycle
  word_t w_rd;
  word_t h_rd_q;
  word_t h_q;

  word_t wt, t1, t2, w_new;

  assign h_wa = 3'(cnt - 4'd1);

  // block word memory: written by the packer, read out once per block
  always_ff @(posedge clk) begin
    if (wr_en) w_mem[wr_addr] <= wr_data;
    w_rd <= w_mem[cnt];
  end

  // chaining memory; entry cnt is read while entry cnt-1 is written back
  always_ff @(posedge clk) begin
    if (state == ST_ADD && cnt != 4'd0) h_mem[h_wa] <= h_q + v[h_wa];
    h_q    <= h_valid_n ? InitH[cnt[2:0]] : h_mem[cnt[2:0]];
    h_rd_q <= h_valid_n ? InitH[h_rd_addr] : h_mem[h_rd_addr];
  end
  assign h_rd_data = h_rd_q;

  always_comb begin
    w_new = sig1(win[14]) + win[9] + sig0(win[1]) + win[0];
    wt    = (rnd < 6'd16) ? win[rnd[3:0]] : w_new;
    t1    = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[rnd] + wt;
    t2    = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_LOAD;
      ST_LOAD:  if (cnt == 4'd15 && rnd == 6'd1) state_next = ST_ROUND;
      ST_ROUND: if (rnd == 6'd63) state_next = ST_ADD;
      ST_ADD:   if (cnt == 4'd8) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rnd       <= '0;
      h_valid_n <= 1'b1;
    end else begin
      state <= state_next;
      if (h_init && state == ST_IDLE) h_valid_n <= 1'b1;
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          rnd <= '0;
        end
        ST_LOAD: begin
          // registered read: rnd[0] marks data valid
          if (rnd == 6'd1) win[cnt - 4'd1] <= w_rd;
          if (rnd == 6'd0) begin
            rnd <= 6'd1;
            cnt <= cnt + 4'd1;
          end else if (cnt == 4'd15) begin
            rnd <= 6'd0;
            cnt <= '0;
          end else begin
            cnt <= cnt + 4'd1;
          end
          if (cnt != 4'd0 && cnt <= 4'd8) v[h_wa] <= h_q;
        end
        ST_ROUND: begin
          if (rnd == 6'd0) begin
            // last word of load lands here
            win[15] <= w_rd;
          end
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          if (rnd >= 6'd16) begin
            for (int i = 0; i < BlockWords - 1; i++) win[i] <= win[i + 1];
            win[15] <= w_new;
          end
          rnd <= rnd + 6'd1;
          cnt <= '0;
        end
        ST_ADD: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd8) h_valid_n <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_ADD) && (cnt == 4'd8);

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == ST_IDLE) else $error("start while busy");
  a_round_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd == 6'd63) |=> state == ST_ADD)
    else $error("round sequence broken");
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> !wr_en) else $error("block write during load");
`endif

endmodule
